// File: sv/scoped_symbol_table_top_defines.svh
// Assertion macros shared by the scoped symbol table modules.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef SCOPED_SYMBOL_TABLE_TOP_DEFINES_SVH
`define SCOPED_SYMBOL_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scoped symbol table: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scoped symbol table: next-cycle check failed");

`endif

// File: sv/sst_pkg.sv
// Shared types and constants for the scoped symbol table.
// No dependencies.
package sst_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int META_W      = 16;
  localparam int VALUE_W     = 64;

  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_LOOKUP = 2'd1;
  localparam action_t ACT_UPDATE = 2'd2;
  localparam action_t ACT_DELETE = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_DUPLICATE = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  typedef struct packed {
    action_t             action;
    logic [7:0]          sym_id;
    logic [7:0]          nest_level;
    logic [VALUE_W-1:0]  value_in;
  } sst_in_t;

  typedef struct packed {
    status_t             status;
    logic [VALUE_W-1:0]  value_out;
  } sst_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic              load;     // capture item, clear scan results
    logic              rd;       // read slot metadata at rd_addr
    logic [SLOT_W-1:0] rd_addr;
    logic              act;      // write back or fetch value
    logic              resp;     // load the result register
  } sst_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
  } sst_sts_t;

endpackage

// File: sv/sst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/sst_ctrl.sv
// Sequencer for the scoped symbol table: accept, slot scan, drain, write-back, result.
// Depends on sst_pkg and the assertion macro header.
`include "scoped_symbol_table_top_defines.svh"

module sst_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output sst_pkg::sst_cmd_t cmd,
  input  sst_pkg::sst_sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_ACT   = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  localparam logic [sst_pkg::SLOT_W-1:0] LAST_SLOT =
    sst_pkg::SLOT_W'(sst_pkg::TABLE_SLOTS - 1);

  logic [2:0]                  state_r, state_nxt;
  logic [sst_pkg::SLOT_W-1:0]  cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.rd_addr = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_SLOT) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last slot compares this cycle
        state_nxt = S_ACT;
      end
      S_ACT: begin
        cmd.act   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `SST_ASSERT_NXT(a_scan_ends_in_drain, (state_r == S_SCAN) && (cnt_r == LAST_SLOT), state_r == S_DRAIN)
  `SST_ASSERT_NXT(a_resp_returns_idle, cmd.resp, state_r == S_IDLE)
  `SST_ASSERT_IMP(a_scan_starts_at_zero, $rose(state_r == S_SCAN), cnt_r == '0)

endmodule

// File: sv/sst_dp.sv
// Datapath for the scoped symbol table: slot memories, valid bits, scan
// compare and result register. Depends on sst_pkg, sst_ram and the macro header.
`include "scoped_symbol_table_top_defines.svh"

module sst_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  sst_pkg::sst_in_t  in_data,
  input  sst_pkg::sst_cmd_t cmd,
  output sst_pkg::sst_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output sst_pkg::sst_out_t out_data
);

  sst_pkg::sst_in_t                item_r;
  logic [sst_pkg::TABLE_SLOTS-1:0] valid_r, valid_nxt;

  logic                       cmp_en_r;
  logic [sst_pkg::SLOT_W-1:0] cmp_idx_r;

  logic                       found_r;
  logic [sst_pkg::SLOT_W-1:0] best_idx_r;
  logic [7:0]                 best_lvl_r;
  logic                       dup_r;
  logic                       free_found_r;
  logic [sst_pkg::SLOT_W-1:0] free_idx_r;

  logic                       out_valid_r;
  sst_pkg::sst_out_t          out_data_r, out_data_nxt;

  logic [sst_pkg::META_W-1:0]  meta_rdata;
  logic [sst_pkg::VALUE_W-1:0] value_rdata;
  logic [7:0]                  slot_sym, slot_lvl;

  logic slot_v, sym_hit, qual, ins_ok, upd_ok, lkp_ok;
  logic meta_we, value_we, value_re;
  logic [sst_pkg::SLOT_W-1:0]  value_waddr;

  assign slot_sym = meta_rdata[15:8];
  assign slot_lvl = meta_rdata[7:0];
  assign slot_v   = valid_r[cmp_idx_r];
  assign sym_hit  = slot_v && (slot_sym == item_r.sym_id);
  assign qual     = sym_hit && (slot_lvl <= item_r.nest_level);

  assign ins_ok = (item_r.action == sst_pkg::ACT_INSERT) && !dup_r && free_found_r;
  assign upd_ok = (item_r.action == sst_pkg::ACT_UPDATE) && found_r;
  assign lkp_ok = (item_r.action == sst_pkg::ACT_LOOKUP) && found_r;

  assign meta_we     = cmd.act && ins_ok;
  assign value_we    = cmd.act && (ins_ok || upd_ok);
  assign value_waddr = ins_ok ? free_idx_r : best_idx_r;
  assign value_re    = cmd.act && lkp_ok;

  sst_ram #(
    .WIDTH (sst_pkg::META_W),
    .DEPTH (sst_pkg::TABLE_SLOTS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (free_idx_r),
    .wdata ({item_r.sym_id, item_r.nest_level}),
    .re    (cmd.rd),
    .raddr (cmd.rd_addr),
    .rdata (meta_rdata)
  );

  sst_ram #(
    .WIDTH (sst_pkg::VALUE_W),
    .DEPTH (sst_pkg::TABLE_SLOTS)
  ) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .waddr (value_waddr),
    .wdata (item_r.value_in),
    .re    (value_re),
    .raddr (best_idx_r),
    .rdata (value_rdata)
  );

  always_comb begin
    valid_nxt = valid_r;
    // drop every entry whose scope is at or above the delete threshold
    if (cmp_en_r && (item_r.action == sst_pkg::ACT_DELETE) && slot_v &&
        (slot_lvl >= item_r.nest_level)) begin
      valid_nxt[cmp_idx_r] = 1'b0;
    end
    if (meta_we) begin
      valid_nxt[free_idx_r] = 1'b1;
    end
  end

  always_comb begin
    out_data_nxt.value_out = lkp_ok ? value_rdata : '0;
    unique case (item_r.action)
      sst_pkg::ACT_INSERT: begin
        if (dup_r) begin
          out_data_nxt.status = sst_pkg::ST_DUPLICATE;
        end else if (!free_found_r) begin
          out_data_nxt.status = sst_pkg::ST_FULL;
        end else begin
          out_data_nxt.status = sst_pkg::ST_OK;
        end
      end
      sst_pkg::ACT_LOOKUP,
      sst_pkg::ACT_UPDATE: begin
        out_data_nxt.status = found_r ? sst_pkg::ST_OK : sst_pkg::ST_NOT_FOUND;
      end
      default: begin
        out_data_nxt.status = sst_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      cmp_en_r <= cmd.rd;
      if (cmd.resp) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmd.rd_addr;
    if (cmd.load) begin
      item_r       <= in_data;
      found_r      <= 1'b0;
      dup_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmp_en_r) begin
      // strict compare keeps the lowest slot on equal depth
      if (qual && (!found_r || (best_lvl_r < slot_lvl))) begin
        found_r    <= 1'b1;
        best_idx_r <= cmp_idx_r;
        best_lvl_r <= slot_lvl;
      end
      if (sym_hit && (slot_lvl == item_r.nest_level)) begin
        dup_r <= 1'b1;
      end
      if (!slot_v && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
    end
    if (cmd.resp) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  `SST_ASSERT_IMP(a_best_within_limit, found_r && !cmd.load, best_lvl_r <= item_r.nest_level)
  `SST_ASSERT_NXT(a_insert_sets_valid, meta_we, valid_r[$past(free_idx_r)])
  `SST_ASSERT_IMP(a_result_only_when_free, cmd.resp, sts.out_free)

endmodule

// File: sv/scoped_symbol_table_top.sv
// Top level of the scoped symbol table: controller plus datapath.
// Depends on sst_pkg, sst_ctrl, sst_dp (and sst_ram below it).
//
//   channel | ports                          | payload
//   input   | in_valid, in_ready, in_data    | action, sym_id, nest_level, value_in
//   result  | out_valid, out_ready, out_data | status, value_out
//
// Each item passes through an accept step, one metadata memory read per slot,
// a compare drain step, a write-back step and the result load. The slot scan
// over the single metadata read port takes most of the time for each item.
// Reset clears the valid bits and control at once; no clearing pass is needed.
// A stalled result holds in the output register; the next item is accepted and
// scanned meanwhile and waits in its result stage until the register frees.
module scoped_symbol_table_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sst_pkg::sst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sst_pkg::sst_out_t out_data
);

  sst_pkg::sst_cmd_t cmd;
  sst_pkg::sst_sts_t sts;

  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sst_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
